[hdl/pai_pkg.sv]
// ----------------------------------------------------------------------------
// pai_pkg
// shared types and constants for the particle attract/integrate step block
// ----------------------------------------------------------------------------
package pai_pkg;

   // fixed point and geometry constants
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned FRAC_W    = 24;
   localparam logic signed [32:0] POS_LIMIT = 33'sd23722983;
   localparam logic [63:0] GUARD_NUM = 64'h0000_0000_0200_0000;   // 2.0 in Q8.24

   // register reset values
   localparam logic [23:0] GRAVITY_RST  = 24'd0;
   localparam logic [24:0] FRICTION_RST = 25'h100_0000;
   localparam logic [15:0] WIDTH_RST    = 16'd800;
   localparam logic [15:0] HEIGHT_RST   = 16'd600;

   // register indexes
   localparam logic [1:0] REG_GRAVITY  = 2'd0;
   localparam logic [1:0] REG_FRICTION = 2'd1;
   localparam logic [1:0] REG_WIDTH    = 2'd2;
   localparam logic [1:0] REG_HEIGHT   = 2'd3;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_CAPT,
      OP_SQX,
      OP_SQY,
      OP_SUM,
      OP_SQRT_GO,
      OP_GUARD_GO,
      OP_DTAKE,
      OP_NX_GO,
      OP_NX_TAKE,
      OP_NY_GO,
      OP_NY_TAKE,
      OP_DEN_X,
      OP_DIVX_GO,
      OP_VX_ADD,
      OP_DEN_Y,
      OP_DIVY_GO,
      OP_VY_ADD,
      OP_GRAV,
      OP_FRX,
      OP_FRX_TAKE,
      OP_FRY,
      OP_FRY_TAKE,
      OP_MOVE,
      OP_PUB
   } dp_op_type;

   typedef struct packed {
      logic      take_in;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic iter_done;
      logic res_zero;
   } dp_stat_type;

endpackage

[hdl/pai_req_if.sv]
// ----------------------------------------------------------------------------
// pai_req_if
// input word channel: load values or step request
// ----------------------------------------------------------------------------
interface pai_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] load_pos_x;
   logic signed [31:0] load_pos_y;
   logic signed [31:0] load_vel_x;
   logic signed [31:0] load_vel_y;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic               do_attract;
   logic               do_gravity;
   logic               do_friction;

   modport source (output valid, mode, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                   target_x, target_y, do_attract, do_gravity, do_friction,
                   input ready);
   modport sink (input valid, mode, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
                 target_x, target_y, do_attract, do_gravity, do_friction,
                 output ready);
endinterface

[hdl/pai_rsp_if.sv]
// ----------------------------------------------------------------------------
// pai_rsp_if
// result word channel: particle state after each word
// ----------------------------------------------------------------------------
interface pai_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;

   modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                   input ready);
   modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                 output ready);
endinterface

[hdl/pai_iter.sv]
// ----------------------------------------------------------------------------
// pai_iter
// shared iterative unit: 64/64 restoring divide or
// 64-bit integer square root, one step per cycle
// ----------------------------------------------------------------------------
module pai_iter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        sqrt_mode,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] res
);
   import pai_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;    // dividend/quotient, or radicand
   logic [63:0] rem_ff, rem_in;    // remainder, or root
   logic [63:0] den_ff, den_in;    // divisor, or root bit

   logic [64:0] shifted;
   logic        div_ge;
   logic [64:0] div_diff;
   logic [63:0] trial;
   logic        sq_ge;

   // one step of either operation
   always_comb begin
      shifted  = {rem_ff, acc_ff[63]};
      div_diff = shifted - {1'b0, den_ff};
      div_ge   = (shifted >= {1'b0, den_ff});
      trial    = rem_ff + den_ff;
      sq_ge    = (acc_ff >= trial);

      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         mode_in = sqrt_mode;
         acc_in  = a;
         rem_in  = '0;
         if (sqrt_mode) begin
            cnt_in = 6'd31;
            den_in = 64'h4000_0000_0000_0000;
         end else begin
            cnt_in = 6'd63;
            den_in = b;
         end
      end else if (busy_ff) begin
         if (mode_ff) begin
            acc_in = sq_ge ? (acc_ff - trial) : acc_ff;
            rem_in = sq_ge ? ((rem_ff >> 1) + den_ff) : (rem_ff >> 1);
            den_in = den_ff >> 2;
         end else begin
            rem_in = div_ge ? div_diff[63:0] : shifted[63:0];
            acc_in = {acc_ff[62:0], div_ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign res  = mode_ff ? rem_ff : acc_ff;

endmodule

[hdl/pai_dp.sv]
// ----------------------------------------------------------------------------
// pai_dp
// datapath: particle state, one shared 32x32 multiplier, the iterative
// divide/root unit and the saturating update logic
// ----------------------------------------------------------------------------
module pai_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  pai_pkg::dp_cmd_type  cmd,
   output pai_pkg::dp_stat_type stat,
   input  logic signed [31:0]   in_pos_x,
   input  logic signed [31:0]   in_pos_y,
   input  logic signed [31:0]   in_vel_x,
   input  logic signed [31:0]   in_vel_y,
   input  logic signed [31:0]   in_tgt_x,
   input  logic signed [31:0]   in_tgt_y,
   input  logic [23:0]          cfg_gravity,
   input  logic [24:0]          cfg_friction,
   input  logic [15:0]          cfg_width,
   input  logic [15:0]          cfg_height,
   output logic signed [31:0]   out_pos_x,
   output logic signed [31:0]   out_pos_y,
   output logic signed [31:0]   out_vel_x,
   output logic signed [31:0]   out_vel_y
);
   import pai_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647)       r = 32'sh7fff_ffff;
      else if (v < -40'sd2147483648) r = 32'sh8000_0000;
      else                            r = v[31:0];
      return r;
   endfunction

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic [32:0] t;
      t = v[32] ? (-v) : v;
      return t[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_pos(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v <= -POS_LIMIT)     r = -POS_LIMIT[31:0];
      else if (v >= POS_LIMIT) r = POS_LIMIT[31:0];
      else                     r = v[31:0];
      return r;
   endfunction

   // latched input word
   logic signed [31:0] lpx_ff, lpy_ff, lvx_ff, lvy_ff, tx_ff, ty_ff;
   // particle state
   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   // step intermediates
   logic signed [32:0] ex_x_ff, ex_y_ff;
   logic [63:0]        prod_ff, sum_ff;
   logic [31:0]        d_ff;
   logic [55:0]        nx_ff, ny_ff;
   // published result
   logic signed [31:0] opx_ff, opy_ff, ovx_ff, ovy_ff;

   logic [15:0] w_eff, h_eff;
   logic [31:0] mx, my;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [64:0] sq_sum;
   logic        it_start, it_sqrt, it_done;
   logic [63:0] it_a, it_b, it_res;
   logic [33:0] inc_mag;
   logic signed [39:0] inc_x, inc_y;
   logic signed [39:0] fr_val;
   logic [32:0] fr_mag;

   assign w_eff = (cfg_width == '0) ? 16'd1 : cfg_width;
   assign h_eff = (cfg_height == '0) ? 16'd1 : cfg_height;
   assign mx    = mag33(ex_x_ff);
   assign my    = mag33(ex_y_ff);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQX:  begin mul_a = mx; mul_b = mx; end
         OP_SQY:  begin mul_a = my; mul_b = my; end
         OP_DEN_X: begin mul_a = d_ff; mul_b = {16'd0, w_eff}; end
         OP_DEN_Y: begin mul_a = d_ff; mul_b = {16'd0, h_eff}; end
         OP_FRX:  begin mul_a = mag33({vel_x_ff[31], vel_x_ff}); mul_b = {7'd0, cfg_friction}; end
         OP_FRY:  begin mul_a = mag33({vel_y_ff[31], vel_y_ff}); mul_b = {7'd0, cfg_friction}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign mul_p  = mul_a * mul_b;
   assign sq_sum = {1'b0, sum_ff} + {1'b0, prod_ff};

   // iterative unit launch
   always_comb begin
      it_start = 1'b0;
      it_sqrt  = 1'b0;
      it_a     = '0;
      it_b     = '0;
      case (cmd.op)
         OP_SQRT_GO:  begin it_start = 1'b1; it_sqrt = 1'b1; it_a = sum_ff; end
         OP_GUARD_GO: begin it_start = 1'b1; it_a = GUARD_NUM; it_b = {48'd0, w_eff}; end
         OP_NX_GO:    begin it_start = 1'b1; it_a = {8'd0, mx, 24'd0}; it_b = {32'd0, d_ff}; end
         OP_NY_GO:    begin it_start = 1'b1; it_a = {8'd0, my, 24'd0}; it_b = {32'd0, d_ff}; end
         OP_DIVX_GO:  begin
            it_start = 1'b1; it_a = {nx_ff[39:0], 24'd0}; it_b = prod_ff + {prod_ff[62:0], 1'b0};
         end
         OP_DIVY_GO:  begin
            it_start = 1'b1; it_a = {ny_ff[39:0], 24'd0}; it_b = prod_ff + {prod_ff[62:0], 1'b0};
         end
         default: begin it_start = 1'b0; end
      endcase
   end

   pai_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .start     (it_start),
      .sqrt_mode (it_sqrt),
      .a         (it_a),
      .b         (it_b),
      .done      (it_done),
      .res       (it_res)
   );

   assign stat = '{iter_done: it_done, res_zero: (it_res == '0)};

   // attraction increment, clipped well past the saturation point
   assign inc_mag = (|it_res[63:33]) ? 34'h2_0000_0000 : it_res[33:0];
   assign inc_x   = ex_x_ff[32] ? -$signed({6'd0, inc_mag}) : $signed({6'd0, inc_mag});
   assign inc_y   = ex_y_ff[32] ? -$signed({6'd0, inc_mag}) : $signed({6'd0, inc_mag});

   // friction: magnitude product back to Q8.24, sign restored
   assign fr_mag = prod_ff[56:24];
   assign fr_val = (cmd.op == OP_FRX_TAKE) ?
                   (vel_x_ff[31] ? -$signed({7'd0, fr_mag}) : $signed({7'd0, fr_mag})) :
                   (vel_y_ff[31] ? -$signed({7'd0, fr_mag}) : $signed({7'd0, fr_mag}));

   // input word latch
   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         lpx_ff <= in_pos_x;
         lpy_ff <= in_pos_y;
         lvx_ff <= in_vel_x;
         lvy_ff <= in_vel_y;
         tx_ff  <= in_tgt_x;
         ty_ff  <= in_tgt_y;
      end
   end

   // particle state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               pos_x_ff <= lpx_ff;
               pos_y_ff <= lpy_ff;
               vel_x_ff <= lvx_ff;
               vel_y_ff <= lvy_ff;
            end
            OP_VX_ADD:   vel_x_ff <= sat32({{8{vel_x_ff[31]}}, vel_x_ff} + inc_x);
            OP_VY_ADD:   vel_y_ff <= sat32({{8{vel_y_ff[31]}}, vel_y_ff} + inc_y);
            OP_GRAV:     vel_y_ff <= sat32({{8{vel_y_ff[31]}}, vel_y_ff} - {16'd0, cfg_gravity});
            OP_FRX_TAKE: vel_x_ff <= sat32(fr_val);
            OP_FRY_TAKE: vel_y_ff <= sat32(fr_val);
            OP_MOVE: begin
               pos_x_ff <= clamp_pos({pos_x_ff[31], pos_x_ff} + {vel_x_ff[31], vel_x_ff});
               pos_y_ff <= clamp_pos({pos_y_ff[31], pos_y_ff} + {vel_y_ff[31], vel_y_ff});
            end
            default: pos_x_ff <= pos_x_ff;
         endcase
      end
   end

   // step intermediates
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPT: begin
            ex_x_ff <= {tx_ff[31], tx_ff} - {pos_x_ff[31], pos_x_ff};
            ex_y_ff <= {ty_ff[31], ty_ff} - {pos_y_ff[31], pos_y_ff};
         end
         OP_SQX, OP_DEN_X, OP_DEN_Y, OP_FRX, OP_FRY: prod_ff <= mul_p;
         OP_SQY: begin
            sum_ff  <= prod_ff;
            prod_ff <= mul_p;
         end
         OP_SUM:     sum_ff <= sq_sum[64] ? '1 : sq_sum[63:0];
         OP_DTAKE:   d_ff   <= it_res[31:0];
         OP_NX_TAKE: nx_ff  <= it_res[55:0];
         OP_NY_TAKE: ny_ff  <= it_res[55:0];
         OP_PUB: begin
            opx_ff <= pos_x_ff;
            opy_ff <= pos_y_ff;
            ovx_ff <= vel_x_ff;
            ovy_ff <= vel_y_ff;
         end
         default: d_ff <= d_ff;
      endcase
   end

   assign out_pos_x = opx_ff;
   assign out_pos_y = opy_ff;
   assign out_vel_x = ovx_ff;
   assign out_vel_y = ovy_ff;

endmodule

[hdl/pai_ctrl.sv]
// ----------------------------------------------------------------------------
// pai_ctrl
// step sequencer: walks the phases of one word and issues datapath commands
// ----------------------------------------------------------------------------
module pai_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   input  logic                 req_attract,
   input  logic                 req_gravity,
   input  logic                 req_friction,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pai_pkg::dp_cmd_type  cmd,
   input  pai_pkg::dp_stat_type stat
);
   import pai_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_A1, S_A2, S_A3, S_A4, S_SQRT_W, S_GUARD_W, S_A5, S_NX_W, S_A6, S_NY_W,
      S_A7, S_A8, S_DIVX_W, S_A9, S_A10, S_DIVY_W, S_PH_G, S_PH_F,
      S_F1, S_F2, S_F3, S_F4, S_FIN, S_PUB
   } state_type;

   state_type state_ff;
   dp_op_type op_ff;
   logic      ready_ff, valid_ff, grav_ff, fric_ff;
   logic      accept;

   assign accept = req_valid & ready_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_NOP;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
         grav_ff  <= 1'b0;
         fric_ff  <= 1'b0;
      end else begin
         op_ff <= OP_NOP;
         if (valid_ff && rsp_ready) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  grav_ff  <= req_gravity;
                  fric_ff  <= req_friction;
                  if (!req_mode) begin
                     op_ff <= OP_LOAD;    state_ff <= S_FIN;
                  end else if (req_attract) begin
                     op_ff <= OP_CAPT;    state_ff <= S_A1;
                  end else begin
                     state_ff <= S_PH_G;
                  end
               end
            end
            S_A1: begin op_ff <= OP_SQX;     state_ff <= S_A2; end
            S_A2: begin op_ff <= OP_SQY;     state_ff <= S_A3; end
            S_A3: begin op_ff <= OP_SUM;     state_ff <= S_A4; end
            S_A4: begin op_ff <= OP_SQRT_GO; state_ff <= S_SQRT_W; end
            S_SQRT_W: begin
               if (stat.iter_done) begin
                  // zero distance: fall back to the width-based guard
                  if (stat.res_zero) begin
                     op_ff <= OP_GUARD_GO; state_ff <= S_GUARD_W;
                  end else begin
                     op_ff <= OP_DTAKE;    state_ff <= S_A5;
                  end
               end
            end
            S_GUARD_W: begin
               if (stat.iter_done) begin op_ff <= OP_DTAKE; state_ff <= S_A5; end
            end
            S_A5: begin op_ff <= OP_NX_GO; state_ff <= S_NX_W; end
            S_NX_W: begin
               if (stat.iter_done) begin op_ff <= OP_NX_TAKE; state_ff <= S_A6; end
            end
            S_A6: begin op_ff <= OP_NY_GO; state_ff <= S_NY_W; end
            S_NY_W: begin
               if (stat.iter_done) begin op_ff <= OP_NY_TAKE; state_ff <= S_A7; end
            end
            S_A7: begin op_ff <= OP_DEN_X;   state_ff <= S_A8; end
            S_A8: begin op_ff <= OP_DIVX_GO; state_ff <= S_DIVX_W; end
            S_DIVX_W: begin
               if (stat.iter_done) begin op_ff <= OP_VX_ADD; state_ff <= S_A9; end
            end
            S_A9:  begin op_ff <= OP_DEN_Y;   state_ff <= S_A10; end
            S_A10: begin op_ff <= OP_DIVY_GO; state_ff <= S_DIVY_W; end
            S_DIVY_W: begin
               if (stat.iter_done) begin op_ff <= OP_VY_ADD; state_ff <= S_PH_G; end
            end
            S_PH_G: begin
               if (grav_ff) begin
                  op_ff <= OP_GRAV;
               end
               state_ff <= S_PH_F;
            end
            S_PH_F: begin
               if (fric_ff) begin
                  op_ff <= OP_FRX;  state_ff <= S_F1;
               end else begin
                  op_ff <= OP_MOVE; state_ff <= S_FIN;
               end
            end
            S_F1: begin op_ff <= OP_FRX_TAKE; state_ff <= S_F2; end
            S_F2: begin op_ff <= OP_FRY;      state_ff <= S_F3; end
            S_F3: begin op_ff <= OP_FRY_TAKE; state_ff <= S_F4; end
            S_F4: begin op_ff <= OP_MOVE;     state_ff <= S_FIN; end
            S_FIN: begin
               // wait until the result register is free
               if (!valid_ff || rsp_ready) begin
                  op_ff <= OP_PUB; state_ff <= S_PUB;
               end
            end
            S_PUB: begin
               valid_ff <= 1'b1;
               ready_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;
   assign cmd       = '{take_in: accept, op: op_ff};

endmodule

[hdl/particle_attract_integrate_step.sv]
// ----------------------------------------------------------------------------
// particle_attract_integrate_step
// one particle's Q8.24 position and velocity: load or attract/gravity/
// friction/move step, one result word per input word
// ----------------------------------------------------------------------------
// attraction uses the shared iterative unit for a square root and four
//   divides, and for one more divide when the zero-distance guard runs
// throughput: one word at a time, the next word is taken as the result is
//   presented, so the iterative divide/root unit and result stalls set the rate
// reset: synchronous, clears state to zero and registers to their defaults
module particle_attract_integrate_step (
   input  logic        clock,
   input  logic        reset,
   pai_req_if.sink     req_ch,
   pai_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pai_pkg::*;

   logic [23:0] gravity_ff;
   logic [24:0] friction_ff;
   logic [15:0] width_ff, height_ff;
   logic        csr_wr;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff  <= GRAVITY_RST;
         friction_ff <= FRICTION_RST;
         width_ff    <= WIDTH_RST;
         height_ff   <= HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_GRAVITY:  gravity_ff  <= csr_pwdata[23:0];
            REG_FRICTION: friction_ff <= csr_pwdata[24:0];
            REG_WIDTH:    width_ff    <= csr_pwdata[15:0];
            REG_HEIGHT:   height_ff   <= csr_pwdata[15:0];
            default:      width_ff    <= width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_GRAVITY:  csr_prdata = {8'd0, gravity_ff};
         REG_FRICTION: csr_prdata = {7'd0, friction_ff};
         REG_WIDTH:    csr_prdata = {16'd0, width_ff};
         REG_HEIGHT:   csr_prdata = {16'd0, height_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // sequencer
   pai_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_mode     (req_ch.mode),
      .req_attract  (req_ch.do_attract),
      .req_gravity  (req_ch.do_gravity),
      .req_friction (req_ch.do_friction),
      .req_ready    (req_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .cmd          (cmd),
      .stat         (stat)
   );

   // datapath
   pai_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_pos_x         (req_ch.load_pos_x),
      .in_pos_y         (req_ch.load_pos_y),
      .in_vel_x         (req_ch.load_vel_x),
      .in_vel_y         (req_ch.load_vel_y),
      .in_tgt_x         (req_ch.target_x),
      .in_tgt_y         (req_ch.target_y),
      .cfg_gravity      (gravity_ff),
      .cfg_friction     (friction_ff),
      .cfg_width        (width_ff),
      .cfg_height       (height_ff),
      .out_pos_x        (rsp_ch.new_pos_x),
      .out_pos_y        (rsp_ch.new_pos_y),
      .out_vel_x        (rsp_ch.new_vel_x),
      .out_vel_y        (rsp_ch.new_vel_y)
   );

   // checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("word accepted while another is in flight");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUB) |=> rsp_ch.valid)
      else $error("published result not presented");

   a_iter_busy: assert property (@(posedge clock) disable iff (reset)
      stat.iter_done |-> !req_ch.ready)
      else $error("iterative unit finished while idle");

endmodule
